### rtl/core/ir_bit_symbol_encoder_macros.svh
// assertion helpers for the ir bit symbol encoder
// both expect clk and rst_n in scope
`ifndef IR_BIT_SYMBOL_ENCODER_MACROS_SVH
`define IR_BIT_SYMBOL_ENCODER_MACROS_SVH

// condition in the same cycle
`define IBSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in the next cycle
`define IBSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ibse_pkg.sv
package ibse_pkg;

    // default sizes
    localparam int PAYLOAD_BITS_DEF  = 8;
    localparam int DURATION_BITS_DEF = 8;

    // fixed field widths
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;
    localparam int TIME_W    = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FIRST       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK_TIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_TIME  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TIME   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK_FIRST  = 3'd7;

    // encoding modes
    localparam logic MODE_PULSE   = 1'b0;
    localparam logic MODE_BIPHASE = 1'b1;

    // register reset values
    localparam logic              RST_ENCODING_MODE   = MODE_PULSE;
    localparam logic              RST_LOW_FIRST       = 1'b1;
    localparam logic [TIME_W-1:0] RST_ZERO_MARK_TIME  = 8'd6;
    localparam logic [TIME_W-1:0] RST_ZERO_SPACE_TIME = 8'd6;
    localparam logic [TIME_W-1:0] RST_ONE_MARK_TIME   = 8'd6;
    localparam logic [TIME_W-1:0] RST_ONE_SPACE_TIME  = 8'd17;
    localparam logic [TIME_W-1:0] RST_HALF_BIT_TIME   = 8'd9;
    localparam logic              RST_ONE_MARK_FIRST  = 1'b0;

    // timing and coding settings
    typedef struct packed {
        logic              encoding_mode;
        logic              low_first;
        logic [TIME_W-1:0] zero_mark_time;
        logic [TIME_W-1:0] zero_space_time;
        logic [TIME_W-1:0] one_mark_time;
        logic [TIME_W-1:0] one_space_time;
        logic [TIME_W-1:0] half_bit_time;
        logic              one_mark_first;
    } cfg_t;

    // bit offered by the shifter
    typedef struct packed {
        logic valid;
        logic value;
        logic last;
    } bit_stream_t;

endpackage

### rtl/core/ibse_shifter.sv
module ibse_shifter #(
    parameter int PAYLOAD_BITS = ibse_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [PAYLOAD_BITS-1:0]       load_data,
    input  logic [ibse_pkg::COUNT_W-1:0]  load_count,
    input  logic                          low_first,
    input  logic                          pop,
    output ibse_pkg::bit_stream_t         stream,
    output logic                          idle
);

    localparam int CNT_W = $clog2(PAYLOAD_BITS + 1);
    localparam int IDX_W = (PAYLOAD_BITS > 1) ? $clog2(PAYLOAD_BITS) : 1;
    localparam logic [5:0] MAX_COUNT = 6'(PAYLOAD_BITS);

    logic [PAYLOAD_BITS-1:0] shift_reg;
    logic [PAYLOAD_BITS-1:0] shift_next;
    logic [CNT_W-1:0]        bits_left_reg;
    logic [CNT_W-1:0]        bits_left_next;
    logic                    lsb_reg;
    logic                    lsb_next;
    logic [IDX_W-1:0]        tap_reg;
    logic [IDX_W-1:0]        tap_next;
    logic [5:0]              count_wide;
    logic [5:0]              count_clamped;

    // clamp the requested count to the payload width
    assign count_wide    = 6'(load_count);
    assign count_clamped = (count_wide > MAX_COUNT) ? MAX_COUNT : count_wide;

    // load, then one bit out per pop
    always_comb
    begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        lsb_next       = lsb_reg;
        tap_next       = tap_reg;
        if (load)
        begin
            shift_next     = load_data;
            bits_left_next = CNT_W'(count_clamped);
            lsb_next       = low_first;
            tap_next       = IDX_W'(count_clamped - 6'd1);
        end
        else if (pop)
        begin
            shift_next     = lsb_reg ? (shift_reg >> 1) : (shift_reg << 1);
            bits_left_next = bits_left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_left_reg <= '0;
            lsb_reg       <= 1'b1;
            tap_reg       <= '0;
        end
        else
        begin
            bits_left_reg <= bits_left_next;
            lsb_reg       <= lsb_next;
            tap_reg       <= tap_next;
        end
    end

    // payload bits need no reset
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // msb-first takes the top bit of the run, which slides up as it shifts left
    assign stream.valid = (bits_left_reg != '0);
    assign stream.last  = (bits_left_reg == CNT_W'(1));
    assign stream.value = lsb_reg ? shift_reg[0] : shift_reg[tap_reg];
    assign idle         = (bits_left_reg == '0);

endmodule

### rtl/core/ibse_segment.sv
module ibse_segment #(
    parameter int DURATION_BITS = ibse_pkg::DURATION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ibse_pkg::cfg_t             cfg,
    input  ibse_pkg::bit_stream_t      stream,
    input  logic                       out_ready,
    output logic                       pop,
    output logic                       out_valid,
    output logic                       out_carrier_on,
    output logic [DURATION_BITS-1:0]   out_duration,
    output logic                       out_last,
    output logic                       second_half
);

    logic                       valid_reg;
    logic                       valid_next;
    logic                       half_reg;
    logic                       half_next;
    logic                       on_reg;
    logic                       on_next;
    logic [DURATION_BITS-1:0]   dur_reg;
    logic [DURATION_BITS-1:0]   dur_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       slot_free;
    logic                       fire;
    logic                       first_on;
    logic [ibse_pkg::TIME_W-1:0] raw_dur;
    logic [DURATION_BITS-1:0]   sat_dur;

    assign slot_free = !valid_reg || out_ready;
    assign fire      = slot_free && stream.valid;
    assign pop       = fire && half_reg;

    // level and length of the segment for the current half
    always_comb
    begin
        if (cfg.encoding_mode == ibse_pkg::MODE_BIPHASE)
        begin
            first_on = (stream.value == cfg.one_mark_first);
            raw_dur  = cfg.half_bit_time;
        end
        else
        begin
            first_on = 1'b1;
            if (half_reg)
                raw_dur = stream.value ? cfg.one_space_time : cfg.zero_space_time;
            else
                raw_dur = stream.value ? cfg.one_mark_time : cfg.zero_mark_time;
        end
    end

    // fit the time into the duration field, saturating when narrower
    generate
        if (DURATION_BITS >= ibse_pkg::TIME_W)
        begin : g_wide
            assign sat_dur = DURATION_BITS'(raw_dur);
        end
        else
        begin : g_narrow
            localparam logic [ibse_pkg::TIME_W-1:0] DUR_MAX =
                ibse_pkg::TIME_W'((1 << DURATION_BITS) - 1);
            assign sat_dur = (raw_dur > DUR_MAX) ? {DURATION_BITS{1'b1}}
                                                 : raw_dur[DURATION_BITS-1:0];
        end
    endgenerate

    // output word register
    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        on_next    = on_reg;
        dur_next   = dur_reg;
        last_next  = last_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            half_next  = !half_reg;
            on_next    = half_reg ? !first_on : first_on;
            dur_next   = sat_dur;
            last_next  = half_reg && stream.last;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        on_reg   <= on_next;
        dur_reg  <= dur_next;
        last_reg <= last_next;
    end

    assign out_valid      = valid_reg;
    assign out_carrier_on = on_reg;
    assign out_duration   = dur_reg;
    assign out_last       = last_reg;
    assign second_half    = half_reg;

endmodule

### rtl/core/ir_bit_symbol_encoder.sv
// Infrared bit symbol encoder. Each input word carries a payload and a bit
// count (1 up to PAYLOAD_BITS, larger counts clamp, zero sends nothing); each
// bit leaves as two carrier segments (carrier_on level on m_tuser, duration on
// m_tdata, m_tlast on the final segment of the word). Pulse width/distance
// mode sends a mark then a space with the 0 or 1 timings; biphase mode sends
// two half-bit segments, one_mark_first choosing which bit value is
// mark-first. The payload goes through a one-bit-per-step shift register and
// each segment passes through the output register; a new word is taken once
// the shifter has emptied, while its final segment may still wait in the output
// register. The user must write settings through cfg_we / cfg_index / cfg_data
// only while no word is in flight; the block itself does not enforce this.
module ir_bit_symbol_encoder #(
    parameter int PAYLOAD_BITS  = ibse_pkg::PAYLOAD_BITS_DEF,
    parameter int DURATION_BITS = ibse_pkg::DURATION_BITS_DEF,
    localparam int S_TDATA_W    = ((PAYLOAD_BITS + ibse_pkg::COUNT_W + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((DURATION_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input word
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [PAYLOAD_BITS-1:0] payload, then bit_count (4 bits), zero fill
    input  logic [S_TDATA_W-1:0]              s_tdata,
    // result word
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [DURATION_BITS-1:0] duration, zero fill
    output logic [M_TDATA_W-1:0]              m_tdata,
    // [0] carrier_on
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast,
    // settings write port
    input  logic                              cfg_we,
    input  logic [ibse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ibse_pkg::CFG_W-1:0]        cfg_data
);

    ibse_pkg::cfg_t        cfg_reg;
    ibse_pkg::bit_stream_t stream;
    logic                  load;
    logic                  pop;
    logic                  idle;
    logic                  second_half;
    logic                  seg_on;
    logic [DURATION_BITS-1:0] seg_dur;

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.encoding_mode   <= ibse_pkg::RST_ENCODING_MODE;
            cfg_reg.low_first       <= ibse_pkg::RST_LOW_FIRST;
            cfg_reg.zero_mark_time  <= ibse_pkg::RST_ZERO_MARK_TIME;
            cfg_reg.zero_space_time <= ibse_pkg::RST_ZERO_SPACE_TIME;
            cfg_reg.one_mark_time   <= ibse_pkg::RST_ONE_MARK_TIME;
            cfg_reg.one_space_time  <= ibse_pkg::RST_ONE_SPACE_TIME;
            cfg_reg.half_bit_time   <= ibse_pkg::RST_HALF_BIT_TIME;
            cfg_reg.one_mark_first  <= ibse_pkg::RST_ONE_MARK_FIRST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ibse_pkg::REG_ENCODING_MODE:   cfg_reg.encoding_mode   <= cfg_data[0];
                ibse_pkg::REG_LOW_FIRST:       cfg_reg.low_first       <= cfg_data[0];
                ibse_pkg::REG_ZERO_MARK_TIME:  cfg_reg.zero_mark_time  <= cfg_data;
                ibse_pkg::REG_ZERO_SPACE_TIME: cfg_reg.zero_space_time <= cfg_data;
                ibse_pkg::REG_ONE_MARK_TIME:   cfg_reg.one_mark_time   <= cfg_data;
                ibse_pkg::REG_ONE_SPACE_TIME:  cfg_reg.one_space_time  <= cfg_data;
                ibse_pkg::REG_HALF_BIT_TIME:   cfg_reg.half_bit_time   <= cfg_data;
                ibse_pkg::REG_ONE_MARK_FIRST:  cfg_reg.one_mark_first  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // take a word once the shifter is empty
    assign s_tready = idle;
    assign load     = s_tvalid && s_tready;

    ibse_shifter #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_shifter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_data  (s_tdata[PAYLOAD_BITS-1:0]),
        .load_count (s_tdata[PAYLOAD_BITS +: ibse_pkg::COUNT_W]),
        .low_first  (cfg_reg.low_first),
        .pop        (pop),
        .stream     (stream),
        .idle       (idle)
    );

    ibse_segment #(
        .DURATION_BITS (DURATION_BITS)
    ) u_segment (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .stream         (stream),
        .out_ready      (m_tready),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_carrier_on (seg_on),
        .out_duration   (seg_dur),
        .out_last       (m_tlast),
        .second_half    (second_half)
    );

    // result word packing
    assign m_tdata    = M_TDATA_W'(seg_dur);
    assign m_tuser[0] = seg_on;

`include "ir_bit_symbol_encoder_macros.svh"

    // a loaded word with bits keeps the input closed next cycle
    `IBSE_ASSERT_NEXT(a_busy_after_load, load && (s_tdata[PAYLOAD_BITS +: ibse_pkg::COUNT_W] != '0), !s_tready, "input open right after loading a non-empty word")
    // a pending second half means the first half still sits in the output
    `IBSE_ASSERT_NOW(a_second_half_shown, second_half, m_tvalid && !m_tlast, "second half pending without a first-half segment on the output")
    // an empty shifter never leaves a bit half sent
    `IBSE_ASSERT_NOW(a_idle_whole_bits, s_tready, !second_half, "shifter empty while a bit is half sent")

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 50;

    // one carrier segment
    typedef struct packed {
        logic       carrier_on;
        logic [7:0] duration;
        logic       last;
    } seg_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // directed row: payload/count or register index/value, optional typed segments
    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] a;
        logic [7:0] b;
        logic       typed;
        logic [1:0] n_typed;
        seg_t       e0;
        seg_t       e1;
    } row_t;

    localparam seg_t NO_SEG = '0;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [S_TDATA_W-1:0]           s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [M_TDATA_W-1:0]           m_tdata;
    logic [0:0]                     m_tuser;
    logic                           m_tlast;
    logic                           cfg_we = 1'b0;
    logic [ibse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ibse_pkg::CFG_W-1:0]     cfg_data = '0;

    ibse_pkg::cfg_t cfg_model;
    seg_t  pending_segs[$];
    row_t  dir_rows[$];
    int    mismatches = 0;
    int    tx_idle_pct = 0;
    int    rx_stall_pct = 0;
    int    rx_hold = 0;

    ir_bit_symbol_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // segments expected for one word under the current settings
    function automatic void encode_segments(input logic [7:0] payload,
                                            input logic [3:0] count);
        int         n;
        logic [7:0] order;
        logic       b;
        logic       first_on;
        logic [7:0] d0;
        logic [7:0] d1;
        n = (count > 4'd8) ? 8 : int'(count);
        order = '0;
        for (int i = 0; i < n; i++)
            order[i] = cfg_model.low_first ? payload[i] : payload[n - 1 - i];
        for (int i = 0; i < n; i++)
        begin
            b = order[i];
            if (cfg_model.encoding_mode == ibse_pkg::MODE_PULSE)
            begin
                first_on = 1'b1;
                d0 = b ? cfg_model.one_mark_time : cfg_model.zero_mark_time;
                d1 = b ? cfg_model.one_space_time : cfg_model.zero_space_time;
            end
            else
            begin
                first_on = (b == cfg_model.one_mark_first);
                d0 = cfg_model.half_bit_time;
                d1 = cfg_model.half_bit_time;
            end
            pending_segs.push_back('{first_on, d0, 1'b0});
            pending_segs.push_back('{~first_on, d1, (i == n - 1)});
        end
    endfunction

    // timing values biased toward the extremes
    function automatic logic [7:0] pick_time(input int phase);
        if (phase == 0)
            return 8'hFF;
        if (phase == 1)
            return 8'h00;
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // settings write, mirrored into the local copy
    task automatic write_setting(input logic [ibse_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            ibse_pkg::REG_ENCODING_MODE:   cfg_model.encoding_mode   = val[0];
            ibse_pkg::REG_LOW_FIRST:       cfg_model.low_first       = val[0];
            ibse_pkg::REG_ZERO_MARK_TIME:  cfg_model.zero_mark_time  = val;
            ibse_pkg::REG_ZERO_SPACE_TIME: cfg_model.zero_space_time = val;
            ibse_pkg::REG_ONE_MARK_TIME:   cfg_model.one_mark_time   = val;
            ibse_pkg::REG_ONE_SPACE_TIME:  cfg_model.one_space_time  = val;
            ibse_pkg::REG_HALF_BIT_TIME:   cfg_model.half_bit_time   = val;
            ibse_pkg::REG_ONE_MARK_FIRST:  cfg_model.one_mark_first  = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one word, record its segments once accepted
    task automatic send_word(input logic [7:0] payload, input logic [3:0] count,
                             input logic typed, input logic [1:0] n_typed,
                             input seg_t e0, input seg_t e1);
        int gap;
        gap = 0;
        cfg_we <= 1'b0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, count, payload};
        do
            @(posedge clk);
        while (!s_tready);
        if (typed)
        begin
            if (n_typed > 0)
            begin
                pending_segs.push_back(e0);
                pending_segs.push_back(e1);
            end
        end
        else
            encode_segments(payload, count);
    endtask

    // wait until every segment is back and the block has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: ready pattern plus long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        seg_t exp_seg;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_segs.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word on=%0b dur=%0d last=%0b",
                         $time, m_tuser[0], m_tdata, m_tlast);
            end
            else
            begin
                exp_seg = pending_segs.pop_front();
                if (m_tuser[0] !== exp_seg.carrier_on || m_tdata !== exp_seg.duration
                    || m_tlast !== exp_seg.last)
                begin
                    mismatches++;
                    $display("%0t: mismatch exp on=%0b dur=%0d last=%0b got on=%0b dur=%0d last=%0b",
                             $time, exp_seg.carrier_on, exp_seg.duration, exp_seg.last,
                             m_tuser[0], m_tdata, m_tlast);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        row_t       row;
        logic [3:0] cnt;
        int         r;
        cfg_model = '{ibse_pkg::RST_ENCODING_MODE, ibse_pkg::RST_LOW_FIRST,
                      ibse_pkg::RST_ZERO_MARK_TIME, ibse_pkg::RST_ZERO_SPACE_TIME,
                      ibse_pkg::RST_ONE_MARK_TIME, ibse_pkg::RST_ONE_SPACE_TIME,
                      ibse_pkg::RST_HALF_BIT_TIME, ibse_pkg::RST_ONE_MARK_FIRST};
        dir_rows = '{
            // reset settings: pulse distance, lsb first
            '{ROW_ITEM, 8'h01, 8'd1, 1'b1, 2'd2, '{1'b1, 8'd6, 1'b0}, '{1'b0, 8'd17, 1'b1}},
            '{ROW_ITEM, 8'h00, 8'd1, 1'b1, 2'd2, '{1'b1, 8'd6, 1'b0}, '{1'b0, 8'd6, 1'b1}},
            // zero bit count sends nothing
            '{ROW_ITEM, 8'hFF, 8'd0, 1'b1, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'hA5, 8'd8, 1'b0, 2'd0, NO_SEG, NO_SEG},
            // oversized counts clamp to eight
            '{ROW_ITEM, 8'hFF, 8'd15, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h5A, 8'd9, 1'b0, 2'd0, NO_SEG, NO_SEG},
            // msb first
            '{ROW_CFG, 8'(ibse_pkg::REG_LOW_FIRST), 8'h00, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h80, 8'd8, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h03, 8'd2, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h0D, 8'd4, 1'b0, 2'd0, NO_SEG, NO_SEG},
            // zero and full-scale durations
            '{ROW_CFG, 8'(ibse_pkg::REG_ZERO_MARK_TIME), 8'h00, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_CFG, 8'(ibse_pkg::REG_ZERO_SPACE_TIME), 8'h00, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_CFG, 8'(ibse_pkg::REG_ONE_MARK_TIME), 8'hFF, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_CFG, 8'(ibse_pkg::REG_ONE_SPACE_TIME), 8'hFF, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h00, 8'd1, 1'b1, 2'd2, '{1'b1, 8'd0, 1'b0}, '{1'b0, 8'd0, 1'b1}},
            '{ROW_ITEM, 8'h01, 8'd1, 1'b1, 2'd2, '{1'b1, 8'd255, 1'b0}, '{1'b0, 8'd255, 1'b1}},
            '{ROW_ITEM, 8'hC3, 8'd8, 1'b0, 2'd0, NO_SEG, NO_SEG},
            // biphase, a one is space first
            '{ROW_CFG, 8'(ibse_pkg::REG_ENCODING_MODE), 8'h01, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_CFG, 8'(ibse_pkg::REG_HALF_BIT_TIME), 8'h00, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h01, 8'd1, 1'b1, 2'd2, '{1'b0, 8'd0, 1'b0}, '{1'b1, 8'd0, 1'b1}},
            '{ROW_ITEM, 8'h00, 8'd1, 1'b1, 2'd2, '{1'b1, 8'd0, 1'b0}, '{1'b0, 8'd0, 1'b1}},
            // biphase, a one is mark first
            '{ROW_CFG, 8'(ibse_pkg::REG_ONE_MARK_FIRST), 8'h01, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_CFG, 8'(ibse_pkg::REG_HALF_BIT_TIME), 8'hFF, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h01, 8'd1, 1'b1, 2'd2, '{1'b1, 8'd255, 1'b0}, '{1'b0, 8'd255, 1'b1}},
            '{ROW_ITEM, 8'h00, 8'd1, 1'b1, 2'd2, '{1'b0, 8'd255, 1'b0}, '{1'b1, 8'd255, 1'b1}},
            '{ROW_ITEM, 8'h96, 8'd8, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'hFF, 8'd0, 1'b1, 2'd0, NO_SEG, NO_SEG},
            // upper data bits of one-bit registers are dropped
            '{ROW_CFG, 8'(ibse_pkg::REG_LOW_FIRST), 8'h03, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_CFG, 8'(ibse_pkg::REG_HALF_BIT_TIME), 8'h09, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h6D, 8'd7, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'hFF, 8'd8, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_CFG, 8'(ibse_pkg::REG_ENCODING_MODE), 8'hFE, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h01, 8'd1, 1'b1, 2'd2, '{1'b1, 8'd255, 1'b0}, '{1'b0, 8'd255, 1'b1}},
            '{ROW_CFG, 8'(ibse_pkg::REG_LOW_FIRST), 8'h02, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'h01, 8'd2, 1'b0, 2'd0, NO_SEG, NO_SEG},
            '{ROW_ITEM, 8'hFF, 8'd12, 1'b0, 2'd0, NO_SEG, NO_SEG}
        };

        // reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_setting(row.a[ibse_pkg::CFG_IDX_W-1:0], row.b);
            end
            else
                send_word(row.a, row.b[3:0], row.typed, row.n_typed, row.e0, row.e1);
        end

        // random phases
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
                default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
            endcase
            write_setting(ibse_pkg::REG_ENCODING_MODE,
                          {7'($urandom_range(127)), 1'(p >> 2)});
            write_setting(ibse_pkg::REG_LOW_FIRST, 8'($urandom_range(255)));
            write_setting(ibse_pkg::REG_ZERO_MARK_TIME, pick_time(p));
            write_setting(ibse_pkg::REG_ZERO_SPACE_TIME, pick_time(p));
            write_setting(ibse_pkg::REG_ONE_MARK_TIME, pick_time(p));
            write_setting(ibse_pkg::REG_ONE_SPACE_TIME, pick_time(p));
            write_setting(ibse_pkg::REG_HALF_BIT_TIME, pick_time(p));
            write_setting(ibse_pkg::REG_ONE_MARK_FIRST, 8'($urandom_range(255)));
            // long receiver hold-off so the input backs up
            if (p == 4)
                rx_hold = 300;
            repeat (WORDS_PER_PHASE)
            begin
                r = $urandom_range(99);
                if (r < 6)
                    cnt = 4'd0;
                else if (r < 14)
                    cnt = 4'($urandom_range(15, 9));
                else
                    cnt = 4'($urandom_range(8, 1));
                send_word(8'($urandom_range(255)), cnt, 1'b0, 2'd0, NO_SEG, NO_SEG);
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ibse_pkg.sv
rtl/core/ibse_shifter.sv
rtl/core/ibse_segment.sv
rtl/core/ir_bit_symbol_encoder.sv
verif/tb.sv
